// ===== design/tar_archive_file_lookup_core_defines.svh =====
// Assertion macros used by the checker file of the lookup core.
`ifndef TAR_ARCHIVE_FILE_LOOKUP_CORE_DEFINES_SVH
`define TAR_ARCHIVE_FILE_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TAFL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TAFL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tafl_pkg.sv =====
package tafl_pkg;

	// Input function codes.
	localparam logic [1:0] FUNC_START  = 2'd0;
	localparam logic [1:0] FUNC_NAME   = 2'd1;
	localparam logic [1:0] FUNC_ARCH   = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// Defaults for the top-level parameters.
	localparam int NAME_MAX_DEF   = 100;
	localparam int ITEM_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF  = 4;

	// Sector and header layout.
	localparam int SECTOR_BYTES = 512;
	localparam int POS_W        = 9;
	localparam int SECT_SH      = 9;
	localparam int HDR_NAME_LEN = 100;
	localparam int SIZE_OFFSET  = 124;
	localparam int SIZE_DIGITS  = 11;
	localparam int SIG_OFFSET   = 257;
	localparam int SIG_LEN      = 5;
	localparam int DECIDE_AT    = SIG_OFFSET + SIG_LEN - 1;

	// Field widths.
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 33;
	localparam int SKIP_W = 25;

	localparam logic [7:0] ASCII_ZERO = 8'h30;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] start_address;
		logic [ADDR_W-1:0] end_address;
		logic [SIZE_W-1:0] file_size;
	} out_item_t;

	// Fill status of a small queue.
	typedef struct packed {
		logic full;
		logic afull;
		logic empty;
	} fifo_stat_t;

	// Characters of the "ustar" signature by position.
	function automatic logic [7:0] sig_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h75;
			3'd1: c = 8'h73;
			3'd2: c = 8'h74;
			3'd3: c = 8'h61;
			3'd4: c = 8'h72;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== design/tafl_fifo.sv =====
module tafl_fifo import tafl_pkg::*; #(
	parameter int DEPTH = ITEM_DEPTH_DEF,
	parameter int WIDTH = $bits(in_item_t)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output fifo_stat_t       stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	// Status flags follow the fill count.
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.afull = (count_q >= CNT_W'(DEPTH - 1));
	assign stat.empty = (count_q == '0);

	assign do_wr   = wr_en && !stat.full;
	assign do_rd   = rd_en && !stat.empty;
	assign rd_data = slot_q[rd_ptr_q];

	// Storage slots carry no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/tafl_front.sv =====
module tafl_front import tafl_pkg::*; #(
	parameter int DEPTH = ITEM_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t item,
	output logic     full,
	output in_item_t head,
	output logic     head_valid,
	input  logic     head_pop
);

	fifo_stat_t       stat;
	logic             keep;
	logic [$bits(in_item_t)-1:0] head_bits;

	// Accept every beat while there is room; unused function codes are dropped here.
	assign full = stat.full;
	assign keep = push && !stat.full && (item.func != FUNC_UNUSED);

	tafl_fifo #(
		.DEPTH(DEPTH),
		.WIDTH($bits(in_item_t))
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (keep),
		.wr_data(item),
		.rd_en  (head_pop),
		.rd_data(head_bits),
		.stat   (stat)
	);

	assign head       = in_item_t'(head_bits);
	assign head_valid = !stat.empty;

endmodule

// ===== design/tafl_scan.sv =====
module tafl_scan import tafl_pkg::*; #(
	parameter int NAME_MAX = NAME_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ADDR_W-1:0] base_address,
	input  in_item_t          item,
	input  logic              item_valid,
	output logic              item_pop,
	input  fifo_stat_t        res_stat,
	output logic              res_push,
	output out_item_t         res
);

	localparam int IDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
	localparam int LEN_W = $clog2(NAME_MAX + 1);

	// First stage state: position within the sector and header bookkeeping.
	logic [POS_W-1:0]  pos_q;
	logic [ADDR_W-1:0] arc_off_q;
	logic [ADDR_W-1:0] hdr_start_q;
	logic [SIZE_W-1:0] size_q;
	logic [SKIP_W-1:0] skip_q;
	logic              data_q;
	logic              nul_q;
	logic              sigbad_q;
	logic [LEN_W-1:0]  want_len_q;
	logic [7:0]        name_mem [NAME_MAX];

	// Second stage: name compare result and the hit decision.
	logic              valid_s2;
	logic [1:0]        func_s2;
	logic              last_s2;
	logic [7:0]        byte_s2;
	logic [7:0]        rdata_s2;
	logic              cmp_s2;
	logic              clr_s2;
	logic              decide_s2;
	logic [SIZE_W-1:0] size_s2;
	logic [ADDR_W-1:0] hstart_s2;
	logic              mismatch_q;
	logic              done_q;

	logic              adv;
	logic              is_start;
	logic              is_name;
	logic              is_arch;
	logic              hdr;
	logic              p0;
	logic              nul_cur;
	logic              sigbad_cur;
	logic              sigbad_new;
	logic [SIZE_W-1:0] size_cur;
	logic [SIZE_W-1:0] size_new;
	logic              in_name;
	logic              in_size;
	logic              in_sig;
	logic [2:0]        sig_idx;
	logic              cmp_en;
	logic              sector_end;
	logic [SKIP_W-1:0] skip_dec;
	logic              name_room;
	logic              arch_s2;
	logic              mism_new;
	logic              hit;
	logic              miss_set;
	logic [SIZE_W:0]   round_up;
	logic [ADDR_W-1:0] start_a;

	// Take the next item only when a result it may cause is sure to find room.
	assign adv      = item_valid && !res_stat.full && !(res_stat.afull && valid_s2);
	assign item_pop = adv;

	assign is_start = (item.func == FUNC_START);
	assign is_name  = (item.func == FUNC_NAME);
	assign is_arch  = (item.func == FUNC_ARCH);

	// Header field decode for the byte at the head of the queue.
	assign hdr        = !data_q;
	assign p0         = (pos_q == '0);
	assign nul_cur    = nul_q && !p0;
	assign sigbad_cur = sigbad_q && !p0;
	assign size_cur   = p0 ? '0 : size_q;
	assign in_name    = (pos_q < POS_W'(HDR_NAME_LEN));
	assign in_size    = (pos_q >= POS_W'(SIZE_OFFSET)) &&
		(pos_q < POS_W'(SIZE_OFFSET + SIZE_DIGITS));
	assign in_sig     = (pos_q >= POS_W'(SIG_OFFSET)) && (pos_q < POS_W'(SIG_OFFSET + SIG_LEN));
	assign sig_idx    = 3'(pos_q - POS_W'(SIG_OFFSET));
	assign sigbad_new = sigbad_cur || (in_sig && (item.data_byte != sig_char(sig_idx)));
	assign size_new   = in_size ?
		({size_cur[SIZE_W-4:0], 3'b000} + SIZE_W'(item.data_byte) - SIZE_W'(ASCII_ZERO)) :
		size_cur;
	assign cmp_en     = hdr && in_name && !nul_cur && (item.data_byte != 8'h00) &&
		((POS_W + 1)'(pos_q) < (POS_W + 1)'(want_len_q));
	assign sector_end = (pos_q == POS_W'(SECTOR_BYTES - 1));
	assign skip_dec   = skip_q - SKIP_W'(skip_q != '0);
	assign name_room  = (want_len_q < LEN_W'(NAME_MAX));

	// Sector position, offsets, size field and header flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			arc_off_q   <= '0;
			hdr_start_q <= '0;
			size_q      <= '0;
			data_q      <= 1'b0;
			nul_q       <= 1'b0;
			sigbad_q    <= 1'b0;
			want_len_q  <= '0;
		end else if (adv) begin
			if (is_start) begin
				pos_q      <= '0;
				arc_off_q  <= '0;
				size_q     <= '0;
				data_q     <= 1'b0;
				nul_q      <= 1'b0;
				sigbad_q   <= 1'b0;
				want_len_q <= '0;
			end else if (is_name) begin
				if (name_room) begin
					want_len_q <= want_len_q + 1'b1;
				end
			end else if (is_arch) begin
				pos_q     <= pos_q + 1'b1;
				arc_off_q <= arc_off_q + 1'b1;
				if (hdr) begin
					if (p0) begin
						hdr_start_q <= arc_off_q + ADDR_W'(SECTOR_BYTES);
					end
					nul_q    <= nul_cur || (in_name && (item.data_byte == 8'h00));
					sigbad_q <= sigbad_new;
					size_q   <= size_new;
				end
				if (sector_end) begin
					data_q <= hdr ? (skip_q != '0) : (skip_dec != '0);
				end
			end
		end
	end

	// Sectors still to skip: set by a miss decision, counted down in data mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
		end else if (adv && is_start) begin
			skip_q <= '0;
		end else if (miss_set) begin
			skip_q <= round_up[SIZE_W:SECT_SH];
		end else if (adv && is_arch) begin
			if (hdr && p0) begin
				skip_q <= '0;
			end else if (!hdr && sector_end) begin
				skip_q <= skip_dec;
			end
		end
	end

	// Wanted name store, written at the fill point and read at the sector position.
	always_ff @(posedge clk) begin
		if (adv && is_name && name_room) begin
			name_mem[want_len_q[IDX_W-1:0]] <= item.data_byte;
		end
		if (adv) begin
			rdata_s2 <= name_mem[pos_q[IDX_W-1:0]];
		end
	end

	// Stage register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			func_s2   <= item.func;
			last_s2   <= item.last;
			byte_s2   <= item.data_byte;
			cmp_s2    <= is_arch && cmp_en;
			clr_s2    <= is_arch && hdr && p0;
			decide_s2 <= is_arch && hdr && (pos_q == POS_W'(DECIDE_AT)) && !sigbad_new;
			size_s2   <= size_new;
			hstart_s2 <= hdr_start_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= adv;
		end
	end

	// Hit decision once the signature has been seen.
	assign arch_s2  = valid_s2 && (func_s2 == FUNC_ARCH) && !done_q;
	assign mism_new = (mismatch_q && !clr_s2) || (cmp_s2 && (byte_s2 != rdata_s2));
	assign hit      = arch_s2 && decide_s2 && !mism_new;
	assign miss_set = arch_s2 && decide_s2 && mism_new;
	assign round_up = {1'b0, size_s2} + (SIZE_W + 1)'(SECTOR_BYTES - 1);
	assign start_a  = base_address + hstart_s2;

	assign res_push          = hit || (arch_s2 && last_s2);
	assign res.found         = hit;
	assign res.start_address = hit ? start_a : '0;
	assign res.end_address   = hit ? (start_a + size_s2[ADDR_W-1:0]) : '0;
	assign res.file_size     = hit ? size_s2 : '0;

	// Name mismatch and lookup-finished flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatch_q <= 1'b0;
			done_q     <= 1'b0;
		end else if (valid_s2 && (func_s2 == FUNC_START)) begin
			mismatch_q <= 1'b0;
			done_q     <= 1'b0;
		end else if (arch_s2) begin
			mismatch_q <= mism_new;
			if (res_push) begin
				done_q <= 1'b1;
			end
		end
	end

endmodule

// ===== design/tar_archive_file_lookup_core.sv =====
// Tar archive file lookup. Push a start beat, then the wanted name one byte per beat, then the
// archive one byte per beat with last set on its final byte. Each 512-byte sector that carries
// the ustar signature is taken as a header; on a name match one result is queued with the
// file's start and end address (base_address added) and its size, and when the archive ends
// without a match one result with found clear and all other fields zero. The core takes one
// beat per clock; a result is decided in the second scan stage and then registered into the
// result queue, and input stalls only when the short result queue cannot hold one more result
// behind the one in the decision stage. base_address may be rewritten only while no lookup is
// under way.
module tar_archive_file_lookup_core import tafl_pkg::*; #(
	parameter int NAME_MAX   = NAME_MAX_DEF,
	parameter int ITEM_DEPTH = ITEM_DEPTH_DEF,
	parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  in_item_t          item,
	output logic              full,
	output logic              empty,
	input  logic              pop,
	output out_item_t         result,
	input  logic              base_we,
	input  logic [ADDR_W-1:0] base_wdata
);

	logic [ADDR_W-1:0]            base_q;
	in_item_t                     head;
	logic                         head_valid;
	logic                         head_pop;
	fifo_stat_t                   res_stat;
	logic                         res_push;
	out_item_t                    res;
	logic [$bits(out_item_t)-1:0] res_bits;

	// Base address register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (base_we) begin
			base_q <= base_wdata;
		end
	end

	// Front: accept and classify beats into the item queue.
	tafl_front #(
		.DEPTH(ITEM_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.head      (head),
		.head_valid(head_valid),
		.head_pop  (head_pop)
	);

	// Back: header scan and match decision.
	tafl_scan #(
		.NAME_MAX(NAME_MAX)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.base_address(base_q),
		.item        (head),
		.item_valid  (head_valid),
		.item_pop    (head_pop),
		.res_stat    (res_stat),
		.res_push    (res_push),
		.res         (res)
	);

	// Result queue towards the consumer.
	tafl_fifo #(
		.DEPTH(OUT_DEPTH),
		.WIDTH($bits(out_item_t))
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res),
		.rd_en  (pop),
		.rd_data(res_bits),
		.stat   (res_stat)
	);

	assign result = out_item_t'(res_bits);
	assign empty  = res_stat.empty;

endmodule

// ===== design/tafl_checker.sv =====
`include "tar_archive_file_lookup_core_defines.svh"

module tafl_checker import tafl_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input out_item_t         result
);

	// A not-found result carries zeros in every other field.
	`TAFL_ASSERT_NOW(a_miss_zero, !empty && !result.found, (result.start_address == '0) && (result.end_address == '0) && (result.file_size == '0), "not-found result with non-zero fields")

	// A found result ends exactly file_size bytes after it starts.
	`TAFL_ASSERT_NOW(a_hit_span, !empty && result.found, result.end_address == (result.start_address + result.file_size[ADDR_W-1:0]), "end address does not match start plus size")

	// A waiting result stays put until it is taken.
	`TAFL_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "waiting result changed before it was taken")

	// Straight after reset no result is waiting.
	`TAFL_ASSERT_NOW(a_reset_empty, $past(!arst_n), empty, "result queue not empty after reset")

	// Straight after reset the input has room.
	`TAFL_ASSERT_NOW(a_reset_room, $past(!arst_n), !full, "input full straight after reset")

endmodule

bind tar_archive_file_lookup_core tafl_checker u_tafl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.result    (result)
);
